>>> hdl/semf_pkg.sv
// ----------------------------------------------------------------------------
// semf_pkg
// Shared widths, payload types, register map and verdict codes of the
// Sampson epipolar match filter.
// ----------------------------------------------------------------------------
package semf_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned COEF_BITS  = 21;

  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned ROW_W    = 63;
  localparam int unsigned FRAC_W   = 6;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned DESC_W   = 16;
  localparam int unsigned ENERGY_W = 32;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned ADDR_W   = $clog2(8 * NUM_REGS);
  localparam int unsigned IDX_W    = ADDR_W - 3;

  localparam logic [ROW_W-1:0]    F_ROW_RESET      = '0;
  localparam logic [FRAC_W-1:0]   FRAC_RESET       = FRAC_W'(20);
  localparam logic [LIMIT_W-1:0]  EPI_LIMIT_RESET  = LIMIT_W'(65536);
  localparam logic [DESC_W-1:0]   DESC_LIMIT_RESET = DESC_W'(65535);
  localparam logic [ENERGY_W-1:0] MIN_ENERGY_RESET = ENERGY_W'(43);

  // homogeneous coordinate 1.0 in Q12.4
  localparam int unsigned ONE_SHIFT = 4;

  localparam int unsigned XS_W    = COORD_BITS + 1;
  localparam int unsigned PROD_W  = COEF_BITS + XS_W;
  localparam int unsigned CONST_W = COEF_BITS + ONE_SHIFT;
  localparam int unsigned FX_W    = COEF_BITS + COORD_BITS + 2;
  localparam int unsigned MAG_W   = FX_W - 1;
  localparam int unsigned MAG_LO  = MAG_W / 2;
  localparam int unsigned MAG_HI  = MAG_W - MAG_LO;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned JJ_W    = SQ_W + 2;

  localparam int unsigned EP_W  = XS_W + FX_W;
  localparam int unsigned K_W   = FX_W + ONE_SHIFT;
  localparam int unsigned E_W   = EP_W + 1;
  localparam int unsigned EM_W  = E_W - 1;
  localparam int unsigned EM_LO = EM_W / 2;
  localparam int unsigned EM_HI = EM_W - EM_LO;
  localparam int unsigned E2_W  = 2 * EM_W;

  localparam int unsigned ERR_SHIFT = 8;
  localparam int unsigned LHS_W     = E2_W + ERR_SHIFT;
  localparam int unsigned JC_W      = (JJ_W + 2) / 3;
  localparam int unsigned LP_W      = LIMIT_W + JC_W;
  localparam int unsigned RHS_W     = LIMIT_W + JJ_W;
  localparam int unsigned CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam int unsigned JJ_SHIFT  = 24;
  localparam int unsigned MAX_FRAC  = (1 << FRAC_W) - 1;
  localparam int unsigned THR_W     = ENERGY_W + 2 * MAX_FRAC;
  localparam int unsigned JJS_W     = JJ_W + JJ_SHIFT;
  localparam int unsigned DEG_W     = (THR_W > JJS_W) ? THR_W : JJS_W;

  typedef enum logic [1:0] {
    VERDICT_KEPT       = 2'd0,
    VERDICT_REJECTED   = 2'd1,
    VERDICT_DEGENERATE = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [FIELD_W-1:0] left_x;
    logic [FIELD_W-1:0] left_y;
    logic [FIELD_W-1:0] right_x;
    logic [FIELD_W-1:0] right_y;
    logic [FIELD_W-1:0] match_distance;
    logic [FIELD_W-1:0] query_index;
    logic [FIELD_W-1:0] train_index;
  } match_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_query_index;
    logic [FIELD_W-1:0] out_train_index;
    logic [FIELD_W-1:0] out_distance;
    verdict_e           verdict;
  } match_out_t;

  typedef struct packed {
    logic [ROW_W-1:0]    f_row0;
    logic [ROW_W-1:0]    f_row1;
    logic [ROW_W-1:0]    f_row2;
    logic [FRAC_W-1:0]   coef_frac_bits;
    logic [LIMIT_W-1:0]  epipolar_limit;
    logic [DESC_W-1:0]   descriptor_limit;
    logic [ENERGY_W-1:0] min_gradient_energy;
  } cfg_t;

endpackage

>>> hdl/semf_pipe.sv
// ----------------------------------------------------------------------------
// semf_pipe
// Nine-stage datapath: F*x1 and F'*x2, algebraic error, gradient energy,
// squared error against the scaled limit, degenerate test and verdict.
// ----------------------------------------------------------------------------
module semf_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  semf_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  semf_pkg::match_in_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output semf_pkg::match_out_t   out_data_o
);
  import semf_pkg::*;

  localparam int unsigned NS = 9;

  typedef struct packed {
    logic [FIELD_W-1:0] match_distance;
    logic [FIELD_W-1:0] query_index;
    logic [FIELD_W-1:0] train_index;
  } meta_t;

  function automatic logic signed [COEF_BITS-1:0] coef(input logic [ROW_W-1:0] row,
                                                       input int unsigned col);
    return $signed(row[col*COEF_BITS +: COEF_BITS]);
  endfunction

  function automatic logic [MAG_W-1:0] fx_mag(input logic signed [FX_W-1:0] v);
    logic [FX_W-1:0] n;
    n = v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [EM_W-1:0] e_mag(input logic signed [E_W-1:0] v);
    logic [E_W-1:0] n;
    n = v[E_W-1] ? E_W'(-v) : E_W'(v);
    return n[EM_W-1:0];
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS-1:0] en;

  logic [ROW_W-1:0] rows [3];
  logic signed [XS_W-1:0] lx, ly, rx, ry;

  meta_t meta_q [NS];
  logic signed [XS_W-1:0] rx_q [2];
  logic signed [XS_W-1:0] ry_q [2];

  logic signed [PROD_W-1:0]  p1_q [3][2];
  logic signed [PROD_W-1:0]  p2_q [3][2];
  logic signed [CONST_W-1:0] k1_q [3];
  logic signed [CONST_W-1:0] k2_q [3];

  logic signed [FX_W-1:0] fx1_q [3];
  logic signed [FX_W-1:0] fx2_q [3];

  logic signed [EP_W-1:0] pe0_q, pe1_q;
  logic signed [K_W-1:0]  pe2_q;
  logic [MAG_W-1:0]       mag_q [4];

  logic signed [E_W-1:0]     e_q;
  logic [2*MAG_HI-1:0]       hh_q [4];
  logic [MAG_HI+MAG_LO-1:0]  hl_q [4];
  logic [2*MAG_LO-1:0]       ll_q [4];

  logic [SQ_W-1:0] sq_q [4];
  logic [EM_W-1:0] em_q;

  logic [JJ_W-1:0]        jj_q;
  logic [2*EM_HI-1:0]     eh2_q;
  logic [EM_HI+EM_LO-1:0] ehl_q;
  logic [2*EM_LO-1:0]     el2_q;

  logic [E2_W-1:0]   e2_q;
  logic [LP_W-1:0]   lp_q [3];
  logic              deg6_q;
  logic [3*JC_W-1:0] jjx;

  logic [E2_W-1:0]  e2b_q;
  logic [RHS_W-1:0] rhs_q;
  logic             deg7_q;

  verdict_e   verdict_d, verdict_q;
  logic [CMP_W-1:0] lhs_cmp, rhs_cmp;

  logic [THR_W-1:0] thr_q;

  assign rows[0] = cfg_i.f_row0;
  assign rows[1] = cfg_i.f_row1;
  assign rows[2] = cfg_i.f_row2;

  assign lx = $signed({1'b0, in_data_i.left_x[COORD_BITS-1:0]});
  assign ly = $signed({1'b0, in_data_i.left_y[COORD_BITS-1:0]});
  assign rx = $signed({1'b0, in_data_i.right_x[COORD_BITS-1:0]});
  assign ry = $signed({1'b0, in_data_i.right_y[COORD_BITS-1:0]});

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign v_in       = {v_q[NS-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= THR_W'(cfg_i.min_gradient_energy) << {cfg_i.coef_frac_bits, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      meta_q[0] <= '{match_distance: in_data_i.match_distance,
                     query_index:    in_data_i.query_index,
                     train_index:    in_data_i.train_index};
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // stage 0: coefficient products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        p1_q[r][0] <= coef(rows[r], 0) * lx;
        p1_q[r][1] <= coef(rows[r], 1) * ly;
        k1_q[r]    <= CONST_W'(coef(rows[r], 2)) <<< ONE_SHIFT;
        p2_q[r][0] <= coef(rows[0], r) * rx;
        p2_q[r][1] <= coef(rows[1], r) * ry;
        k2_q[r]    <= CONST_W'(coef(rows[2], r)) <<< ONE_SHIFT;
      end
      rx_q[0] <= rx;
      ry_q[0] <= ry;
    end
  end

  // stage 1: F*x1 and F'*x2
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        fx1_q[r] <= FX_W'(p1_q[r][0]) + FX_W'(p1_q[r][1]) + FX_W'(k1_q[r]);
        fx2_q[r] <= FX_W'(p2_q[r][0]) + FX_W'(p2_q[r][1]) + FX_W'(k2_q[r]);
      end
      rx_q[1] <= rx_q[0];
      ry_q[1] <= ry_q[0];
    end
  end

  // stage 2: error products, gradient magnitudes
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pe0_q    <= rx_q[1] * fx1_q[0];
      pe1_q    <= ry_q[1] * fx1_q[1];
      pe2_q    <= K_W'(fx1_q[2]) <<< ONE_SHIFT;
      mag_q[0] <= fx_mag(fx1_q[0]);
      mag_q[1] <= fx_mag(fx1_q[1]);
      mag_q[2] <= fx_mag(fx2_q[0]);
      mag_q[3] <= fx_mag(fx2_q[1]);
    end
  end

  // stage 3: error sum, partial squares
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      e_q <= E_W'(pe0_q) + E_W'(pe1_q) + E_W'(pe2_q);
      for (int i = 0; i < 4; i++) begin
        hh_q[i] <= mag_q[i][MAG_W-1 -: MAG_HI] * mag_q[i][MAG_W-1 -: MAG_HI];
        hl_q[i] <= mag_q[i][MAG_W-1 -: MAG_HI] * mag_q[i][MAG_LO-1:0];
        ll_q[i] <= mag_q[i][MAG_LO-1:0] * mag_q[i][MAG_LO-1:0];
      end
    end
  end

  // stage 4: assemble squares, error magnitude
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= (SQ_W'(hh_q[i]) << (2 * MAG_LO)) + (SQ_W'(hl_q[i]) << (MAG_LO + 1))
                 + SQ_W'(ll_q[i]);
      end
      em_q <= e_mag(e_q);
    end
  end

  // stage 5: gradient energy, partial error square
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      jj_q  <= JJ_W'(sq_q[0]) + JJ_W'(sq_q[1]) + JJ_W'(sq_q[2]) + JJ_W'(sq_q[3]);
      eh2_q <= em_q[EM_W-1 -: EM_HI] * em_q[EM_W-1 -: EM_HI];
      ehl_q <= em_q[EM_W-1 -: EM_HI] * em_q[EM_LO-1:0];
      el2_q <= em_q[EM_LO-1:0] * em_q[EM_LO-1:0];
    end
  end

  // stage 6: error square, limit products, degenerate test
  assign jjx = (3 * JC_W)'(jj_q);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      e2_q <= (E2_W'(eh2_q) << (2 * EM_LO)) + (E2_W'(ehl_q) << (EM_LO + 1)) + E2_W'(el2_q);
      for (int j = 0; j < 3; j++) begin
        lp_q[j] <= cfg_i.epipolar_limit * jjx[j*JC_W +: JC_W];
      end
      deg6_q <= (DEG_W'(jj_q) << JJ_SHIFT) < DEG_W'(thr_q);
    end
  end

  // stage 7: scaled limit
  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      rhs_q  <= RHS_W'(lp_q[0]) + (RHS_W'(lp_q[1]) << JC_W) + (RHS_W'(lp_q[2]) << (2 * JC_W));
      e2b_q  <= e2_q;
      deg7_q <= deg6_q;
    end
  end

  // stage 8: verdict
  assign lhs_cmp = CMP_W'(e2b_q) << ERR_SHIFT;
  assign rhs_cmp = CMP_W'(rhs_q);

  always_comb begin
    priority if (deg7_q) begin
      verdict_d = VERDICT_DEGENERATE;
    end else if (lhs_cmp <= rhs_cmp &&
                 meta_q[NS-2].match_distance < cfg_i.descriptor_limit) begin
      verdict_d = VERDICT_KEPT;
    end else begin
      verdict_d = VERDICT_REJECTED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = v_q[NS-1];

  always_comb begin
    out_data_o.out_query_index = meta_q[NS-1].query_index;
    out_data_o.out_train_index = meta_q[NS-1].train_index;
    out_data_o.out_distance    = meta_q[NS-1].match_distance;
    out_data_o.verdict         = verdict_q;
  end

endmodule

>>> hdl/sampson_epipolar_match_filter.sv
// ----------------------------------------------------------------------------
// sampson_epipolar_match_filter: Sampson error match filter, one verdict/match
// Accepts one beat per cycle while the output is not stalled.
// The ready chain lets a stalled output fill empty stages behind it.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module sampson_epipolar_match_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [semf_pkg::ADDR_W-1:0]   paddr,
  input  logic [semf_pkg::DATA_W-1:0]   pwdata,
  output logic [semf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  semf_pkg::match_in_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output semf_pkg::match_out_t          out_data_o
);
  import semf_pkg::*;

  localparam logic [IDX_W-1:0] REG_F_ROW0      = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_F_ROW1      = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_F_ROW2      = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_FRAC_BITS   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_EPI_LIMIT   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_DESC_LIMIT  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_MIN_ENERGY  = IDX_W'(6);

  cfg_t             cfg_q;
  logic             wr_en;
  logic [IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.f_row0              <= F_ROW_RESET;
      cfg_q.f_row1              <= F_ROW_RESET;
      cfg_q.f_row2              <= F_ROW_RESET;
      cfg_q.coef_frac_bits      <= FRAC_RESET;
      cfg_q.epipolar_limit      <= EPI_LIMIT_RESET;
      cfg_q.descriptor_limit    <= DESC_LIMIT_RESET;
      cfg_q.min_gradient_energy <= MIN_ENERGY_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_F_ROW0:     cfg_q.f_row0              <= pwdata[ROW_W-1:0];
        REG_F_ROW1:     cfg_q.f_row1              <= pwdata[ROW_W-1:0];
        REG_F_ROW2:     cfg_q.f_row2              <= pwdata[ROW_W-1:0];
        REG_FRAC_BITS:  cfg_q.coef_frac_bits      <= pwdata[FRAC_W-1:0];
        REG_EPI_LIMIT:  cfg_q.epipolar_limit      <= pwdata[LIMIT_W-1:0];
        REG_DESC_LIMIT: cfg_q.descriptor_limit    <= pwdata[DESC_W-1:0];
        REG_MIN_ENERGY: cfg_q.min_gradient_energy <= pwdata[ENERGY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_F_ROW0:     prdata = DATA_W'(cfg_q.f_row0);
      REG_F_ROW1:     prdata = DATA_W'(cfg_q.f_row1);
      REG_F_ROW2:     prdata = DATA_W'(cfg_q.f_row2);
      REG_FRAC_BITS:  prdata = DATA_W'(cfg_q.coef_frac_bits);
      REG_EPI_LIMIT:  prdata = DATA_W'(cfg_q.epipolar_limit);
      REG_DESC_LIMIT: prdata = DATA_W'(cfg_q.descriptor_limit);
      REG_MIN_ENERGY: prdata = DATA_W'(cfg_q.min_gradient_energy);
      default:        prdata = '0;
    endcase
  end

  semf_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/sampson_epipolar_match_filter_tb.sv
// ----------------------------------------------------------------------------
// sampson_epipolar_match_filter_tb
// Streams stereo matches through the filter and checks every verdict beat
// against an exact big-integer Sampson error model kept in the bench. The
// fundamental matrix and thresholds are loaded over the APB port between
// phases: reset values, a zero matrix, coefficient and fraction extremes,
// hand-built rectified pairs, then random phases that mostly send matches
// lying near the epipolar line, with random idling on both channels.
// ----------------------------------------------------------------------------
module sampson_epipolar_match_filter_tb;
  import semf_pkg::*;

  typedef enum int unsigned {
    REG_F_ROW0,
    REG_F_ROW1,
    REG_F_ROW2,
    REG_COEF_FRAC,
    REG_EPI_LIMIT,
    REG_DESC_LIMIT,
    REG_MIN_ENERGY
  } reg_idx_e;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_BEATS   = 250;

  localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  match_in_t           in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  match_out_t          out_data_o;

  cfg_t                filter_cfg;
  match_out_t          pending_verdicts [$];
  int unsigned         mismatch_count = 0;
  int unsigned         stall_cycles   = 0;
  logic                steady         = 1'b0;

  sampson_epipolar_match_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [255:0] square_mag(input logic signed [127:0] v);
    logic [127:0] mag;
    mag = v[127] ? 128'(-v) : 128'(v);
    return 256'(mag) * 256'(mag);
  endfunction

  function automatic match_out_t judge_match(input match_in_t m);
    logic [ROW_W-1:0]    rows [3];
    logic signed [63:0]  coef [3][3];
    logic signed [63:0]  p1 [3];
    logic signed [63:0]  p2 [3];
    logic signed [63:0]  fx1 [3];
    logic signed [63:0]  fx2 [3];
    logic signed [127:0] err;
    logic [255:0]        energy;
    match_out_t          res;
    rows[0] = filter_cfg.f_row0;
    rows[1] = filter_cfg.f_row1;
    rows[2] = filter_cfg.f_row2;
    p1[0] = {48'd0, m.left_x};
    p1[1] = {48'd0, m.left_y};
    p1[2] = 64'sd1 <<< ONE_SHIFT;
    p2[0] = {48'd0, m.right_x};
    p2[1] = {48'd0, m.right_y};
    p2[2] = 64'sd1 <<< ONE_SHIFT;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        coef[r][c] = 64'($signed(rows[r][c*COEF_BITS +: COEF_BITS]));
    err = '0;
    energy = '0;
    for (int r = 0; r < 3; r++) begin
      fx1[r] = '0;
      fx2[r] = '0;
      for (int c = 0; c < 3; c++) begin
        fx1[r] += coef[r][c] * p1[c];
        fx2[r] += coef[c][r] * p2[c];
      end
    end
    for (int r = 0; r < 3; r++) err += 128'(p2[r]) * 128'(fx1[r]);
    for (int r = 0; r < 2; r++)
      energy += square_mag(128'(fx1[r])) + square_mag(128'(fx2[r]));
    res.out_query_index = m.query_index;
    res.out_train_index = m.train_index;
    res.out_distance    = m.match_distance;
    if ((energy << JJ_SHIFT) <
        (256'(filter_cfg.min_gradient_energy) << (2 * filter_cfg.coef_frac_bits))) begin
      res.verdict = VERDICT_DEGENERATE;
    end else if ((square_mag(err) << ERR_SHIFT) <= 256'(filter_cfg.epipolar_limit) * energy
                 && m.match_distance < filter_cfg.descriptor_limit) begin
      res.verdict = VERDICT_KEPT;
    end else begin
      res.verdict = VERDICT_REJECTED;
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(input logic [COEF_BITS-1:0] c0,
                                                input logic [COEF_BITS-1:0] c1,
                                                input logic [COEF_BITS-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic match_in_t match_of(input logic [15:0] lx, input logic [15:0] ly,
                                         input logic [15:0] rx, input logic [15:0] ry,
                                         input logic [15:0] md, input logic [15:0] q,
                                         input logic [15:0] t);
    match_in_t m;
    m.left_x         = lx;
    m.left_y         = ly;
    m.right_x        = rx;
    m.right_y        = ry;
    m.match_distance = md;
    m.query_index    = q;
    m.train_index    = t;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_F_ROW0:     filter_cfg.f_row0              = val[ROW_W-1:0];
      REG_F_ROW1:     filter_cfg.f_row1              = val[ROW_W-1:0];
      REG_F_ROW2:     filter_cfg.f_row2              = val[ROW_W-1:0];
      REG_COEF_FRAC:  filter_cfg.coef_frac_bits      = val[FRAC_W-1:0];
      REG_EPI_LIMIT:  filter_cfg.epipolar_limit      = val[LIMIT_W-1:0];
      REG_DESC_LIMIT: filter_cfg.descriptor_limit    = val[DESC_W-1:0];
      REG_MIN_ENERGY: filter_cfg.min_gradient_energy = val[ENERGY_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_match(input match_in_t m);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts = {pending_verdicts, judge_match(m)};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_match(match_of('0, '0, '0, '0, '0, '0, '0));
    send_match(match_of('1, '1, '1, '1, '1, '1, '1));
    send_match(match_of(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'd1, 16'hAAAA, 16'h5555));
    wait_drained();
  endtask

  task automatic test_zero_matrix();
    write_reg(REG_MIN_ENERGY, '0);
    send_match(match_of(16'h1234, 16'h0F00, 16'h0ABC, 16'h0F10, 16'd0, 16'd1, 16'd2));
    send_match(match_of(16'h1234, 16'h0F00, 16'h0ABC, 16'h0F10, 16'hFFFF, 16'd3, 16'd4));
    wait_drained();
    write_reg(REG_EPI_LIMIT, '0);
    send_match(match_of('1, '1, '1, '1, 16'd7, 16'd5, 16'd6));
    wait_drained();
  endtask

  task automatic test_coefficient_extremes();
    write_reg(REG_F_ROW0, {1'b0, pack_row(COEF_MIN, COEF_MIN, COEF_MIN)});
    write_reg(REG_F_ROW1, '1);
    write_reg(REG_F_ROW2, {1'b1, pack_row(COEF_MAX, COEF_MAX, COEF_MAX)});
    write_reg(REG_COEF_FRAC, '0);
    write_reg(REG_EPI_LIMIT, 64'hFFFF_FFFF);
    write_reg(REG_DESC_LIMIT, 64'hFFFF);
    write_reg(REG_MIN_ENERGY, 64'hFFFF_FFFF);
    send_match(match_of('1, '1, '1, '1, 16'd10, 16'hFFFF, 16'h0000));
    send_match(match_of('0, '0, '0, '0, 16'd10, 16'h0000, 16'hFFFF));
    send_match(match_of(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'd10, 16'd8, 16'd9));
    wait_drained();
    write_reg(REG_COEF_FRAC, 64'd63);
    write_reg(REG_MIN_ENERGY, 64'd1);
    send_match(match_of(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'd0, 16'd10, 16'd11));
    wait_drained();
    write_reg(REG_COEF_FRAC, 64'd40);
    send_match(match_of(16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'd0, 16'd12, 16'd13));
    wait_drained();
  endtask

  task automatic test_rectified_thresholds();
    write_reg(REG_F_ROW0, '0);
    write_reg(REG_F_ROW1, {1'b0, pack_row('0, '0, COEF_BITS'(-1000))});
    write_reg(REG_F_ROW2, {1'b0, pack_row('0, COEF_BITS'(1000), '0)});
    write_reg(REG_COEF_FRAC, 64'd20);
    write_reg(REG_EPI_LIMIT, 64'd65536);
    write_reg(REG_DESC_LIMIT, 64'd100);
    write_reg(REG_MIN_ENERGY, 64'd43);
    send_match(match_of(16'h2000, 16'h1800, 16'h1C00, 16'h1800, 16'd99, 16'd20, 16'd21));
    send_match(match_of(16'h2000, 16'h1800, 16'h1C00, 16'h1800, 16'd100, 16'd22, 16'd23));
    send_match(match_of(16'h2000, 16'h1800, 16'h1C00, 16'h1801, 16'd5, 16'd24, 16'd25));
    send_match(match_of(16'h2000, 16'h1800, 16'h1C00, 16'h2740, 16'd5, 16'd26, 16'd27));
    wait_drained();
    write_reg(REG_DESC_LIMIT, '0);
    send_match(match_of(16'h2000, 16'h1800, 16'h1C00, 16'h1800, 16'd0, 16'd28, 16'd29));
    wait_drained();
  endtask

  task automatic load_random_filter();
    logic [COEF_BITS-1:0] gain;
    logic [COEF_BITS-1:0] jit [9];
    logic [ROW_W-1:0]     rows [3];
    wait_drained();
    gain = COEF_BITS'($urandom_range(1, 20'hFFFFF) >> $urandom_range(19));
    if (gain == '0) gain = COEF_BITS'(1);
    if ($urandom_range(1)) gain = -gain;
    for (int i = 0; i < 9; i++)
      jit[i] = ($urandom_range(3) == 0) ?
               COEF_BITS'($urandom_range(7)) - COEF_BITS'(4) : '0;
    if ($urandom_range(99) < 70) begin
      rows[0] = pack_row(jit[0], jit[1], jit[2]);
      rows[1] = pack_row(jit[3], jit[4], jit[5] - gain);
      rows[2] = pack_row(jit[6], jit[7] + gain, jit[8]);
    end else begin
      for (int i = 0; i < 3; i++) rows[i] = ROW_W'({$urandom, $urandom});
    end
    write_reg(REG_F_ROW0, {1'($urandom_range(1)), rows[0]});
    write_reg(REG_F_ROW1, {1'($urandom_range(1)), rows[1]});
    write_reg(REG_F_ROW2, {1'($urandom_range(1)), rows[2]});
    write_reg(REG_COEF_FRAC, {58'($urandom),
              FRAC_W'(($urandom_range(99) < 85) ? $urandom_range(40) : $urandom_range(41, 63))});
    write_reg(REG_EPI_LIMIT, {32'($urandom), 32'($urandom >> $urandom_range(31))});
    write_reg(REG_DESC_LIMIT, {48'($urandom),
              ($urandom_range(1) ? 16'hFFFF : 16'($urandom_range(65535)))});
    write_reg(REG_MIN_ENERGY, {32'($urandom),
              (($urandom_range(4) == 0) ? 32'd0 : 32'($urandom >> $urandom_range(31)))});
  endtask

  task automatic test_random_matches();
    match_in_t m;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_random_filter();
      steady = (phase == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // hold the sender until the pipe is empty
        if (phase == 5 && n == PHASE_BEATS / 2) wait_drained();
        m = match_of(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(99) < 80) begin
          m.right_y = m.left_y + 16'($urandom_range(128)) - 16'd64;
          if ($urandom_range(1)) m.match_distance = 16'($urandom_range(255));
        end
        send_match(m);
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 28);

  always @(posedge clk_i) begin
    match_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("beat with no match pending", 64'(out_data_o), '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data_o.out_query_index !== want.out_query_index)
          report_mismatch("query index", 64'(out_data_o.out_query_index),
                          64'(want.out_query_index));
        if (out_data_o.out_train_index !== want.out_train_index)
          report_mismatch("train index", 64'(out_data_o.out_train_index),
                          64'(want.out_train_index));
        if (out_data_o.out_distance !== want.out_distance)
          report_mismatch("distance", 64'(out_data_o.out_distance), 64'(want.out_distance));
        if (out_data_o.verdict !== want.verdict)
          report_mismatch("verdict", 64'(out_data_o.verdict), 64'(want.verdict));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[sampson_epipolar_match_filter] ERROR");
      $finish;
    end
  end

  initial begin
    filter_cfg.f_row0              = F_ROW_RESET;
    filter_cfg.f_row1              = F_ROW_RESET;
    filter_cfg.f_row2              = F_ROW_RESET;
    filter_cfg.coef_frac_bits      = FRAC_RESET;
    filter_cfg.epipolar_limit      = EPI_LIMIT_RESET;
    filter_cfg.descriptor_limit    = DESC_LIMIT_RESET;
    filter_cfg.min_gradient_energy = MIN_ENERGY_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_matrix();
    test_coefficient_extremes();
    test_rectified_thresholds();
    test_random_matches();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[sampson_epipolar_match_filter] OK");
    end else begin
      $display("[sampson_epipolar_match_filter] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/semf_pkg.sv
hdl/semf_pipe.sv
hdl/sampson_epipolar_match_filter.sv
tb/sampson_epipolar_match_filter_tb.sv
